// ===== rtl/sorted_unique_key_list_core_macros.svh =====
// Assertion macros shared by the checker of sorted_unique_key_list_core.
// No dependencies; include by bare file name.
`ifndef SORTED_UNIQUE_KEY_LIST_CORE_MACROS_SVH
`define SORTED_UNIQUE_KEY_LIST_CORE_MACROS_SVH

// Plain property, checked on every rising edge outside reset.
`define SULC_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("sulc assertion failed");

// Same-cycle implication.
`define SULC_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sulc implication failed");

// Next-cycle implication.
`define SULC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sulc next-cycle implication failed");

`endif

// ===== rtl/sulc_pkg.sv =====
// Package for the sorted unique key list: action and status codes, cell command.
// No dependencies.
`timescale 1ns / 1ps

package sulc_pkg;

  localparam int unsigned KeyW = 32;

  typedef enum logic [1:0] {
    ActAdd    = 2'd0,
    ActRemove = 2'd1,
    ActPop    = 2'd2,
    ActClear  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StDup      = 3'd1,
    StNotFound = 3'd2,
    StEmpty    = 3'd3,
    StFull     = 3'd4
  } status_e;

  // Broadcast to every cell in the transaction cycle
  typedef struct packed {
    logic            ins;      // insert key, cells at or above its place shift up
    logic            del;      // close a gap, cells at or above the match shift down
    logic            del_all;  // pop: every cell shifts down
    logic [KeyW-1:0] key;
  } cell_cmd_t;

endpackage

// ===== rtl/sulc_cell.sv =====
// One storage cell of the sorted key chain: holds a key, compares it with the
// broadcast key and shifts to or from its neighbors. Depends on sulc_pkg.
`timescale 1ns / 1ps

module sulc_cell import sulc_pkg::*; (
  input  logic            clk_i,
  input  cell_cmd_t       cmd_i,
  input  logic            occupied_i,
  input  logic [KeyW-1:0] left_key_i,
  input  logic            left_lt_i,
  input  logic [KeyW-1:0] right_key_i,
  output logic [KeyW-1:0] key_o,
  output logic            lt_o,
  output logic            eq_o
);

  logic [KeyW-1:0] key_q, key_d;
  logic            we;

  // Compare against broadcast key, only meaningful while occupied
  assign lt_o = occupied_i && (key_q < cmd_i.key);
  assign eq_o = occupied_i && (key_q == cmd_i.key);

  // Next key: insert at the boundary, shift up above it, or shift down
  always_comb begin
    we    = 1'b0;
    key_d = key_q;
    if (cmd_i.ins && !lt_o) begin
      we    = 1'b1;
      key_d = left_lt_i ? cmd_i.key : left_key_i;
    end else if (cmd_i.del && (cmd_i.del_all || !lt_o)) begin
      we    = 1'b1;
      key_d = right_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      key_q <= key_d;
    end
  end

  assign key_o = key_q;

endmodule

// ===== rtl/sorted_unique_key_list_core.sv =====
// Sorted list of up to DEPTH distinct 32-bit keys, ascending.
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries action_i and key_value_i:
//   add, remove, pop smallest or clear. Every input transaction gives exactly
//   one output transaction (popped_key_o, status_o, entries_held_o).
//   The result appears in the cycle after the input transaction, from the
//   output register. Throughput: one transaction per cycle while the receiver
//   takes results; each item is done by the row of cells, which all compare
//   against the key in parallel and shift to their neighbors on the same edge.
//   in_ready_o is high while the output register is empty or being drained, so
//   a stalled receiver holds the result and stops the input after one item.
//   Reset empties the list (count goes to zero) and drops any pending result;
//   in_ready_o is already high during reset, so the sender keeps in_valid_i low
//   until reset is released, and the block takes input from the first edge after.
//   Full add drops the largest key with status "full"; a pop on an empty list
//   returns zero with status "empty". Depends on sulc_pkg and sulc_cell.
`timescale 1ns / 1ps

module sorted_unique_key_list_core import sulc_pkg::*; #(
  parameter int unsigned DEPTH = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      action_i,
  input  logic [KeyW-1:0] key_value_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [KeyW-1:0] popped_key_o,
  output logic [2:0]      status_o,
  output logic [3:0]      entries_held_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0] occ_q, occ_d;
  logic            out_valid_q;
  logic [KeyW-1:0] popped_q, popped_d;
  status_e         status_q, status_d;
  logic [3:0]      entries_q;
  logic [CntW+3:0] occ_ext;

  logic            in_fire;
  cell_cmd_t       cmd;
  logic            ins, del, del_all;

  logic [KeyW-1:0] cell_key [DEPTH];
  logic [DEPTH-1:0] lt_vec, eq_vec, occupied;
  logic            any_eq, all_lt, full;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // Chain of cells
  assign cmd.ins     = ins && in_fire;
  assign cmd.del     = del && in_fire;
  assign cmd.del_all = del_all;
  assign cmd.key     = key_value_i;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [KeyW-1:0] left_key, right_key;
    logic            left_lt;

    assign occupied[g] = (occ_q > CntW'(g));

    if (g == 0) begin : g_first
      assign left_key = key_value_i;
      assign left_lt  = 1'b1;
    end else begin : g_mid
      assign left_key = cell_key[g-1];
      assign left_lt  = lt_vec[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_key = cell_key[g];
    end else begin : g_inner
      assign right_key = cell_key[g+1];
    end

    sulc_cell u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd),
      .occupied_i (occupied[g]),
      .left_key_i (left_key),
      .left_lt_i  (left_lt),
      .right_key_i(right_key),
      .key_o      (cell_key[g]),
      .lt_o       (lt_vec[g]),
      .eq_o       (eq_vec[g])
    );
  end

  assign any_eq = |eq_vec;
  assign all_lt = &lt_vec;
  assign full   = (occ_q == CntW'(DEPTH));

  // Decode action into cell command, status and new count
  always_comb begin
    ins      = 1'b0;
    del      = 1'b0;
    del_all  = 1'b0;
    occ_d    = occ_q;
    status_d = StOk;
    popped_d = '0;
    unique case (action_e'(action_i))
      ActAdd: begin
        if (any_eq) begin
          status_d = StDup;
        end else if (full) begin
          status_d = StFull;
          ins      = !all_lt;
        end else begin
          ins   = 1'b1;
          occ_d = occ_q + CntW'(1);
        end
      end
      ActRemove: begin
        if (any_eq) begin
          del   = 1'b1;
          occ_d = occ_q - CntW'(1);
        end else begin
          status_d = StNotFound;
        end
      end
      ActPop: begin
        if (occ_q == '0) begin
          status_d = StEmpty;
        end else begin
          del      = 1'b1;
          del_all  = 1'b1;
          popped_d = cell_key[0];
          occ_d    = occ_q - CntW'(1);
        end
      end
      ActClear: begin
        occ_d = '0;
      end
      default: begin
        occ_d = occ_q;
      end
    endcase
  end

  assign occ_ext = {4'b0000, occ_d};

  // Count and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        occ_q <= occ_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      popped_q  <= popped_d;
      status_q  <= status_d;
      entries_q <= occ_ext[3:0];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign popped_key_o   = popped_q;
  assign status_o       = status_q;
  assign entries_held_o = entries_q;

endmodule

// ===== rtl/sulc_checker.sv =====
// Port-level checker for sorted_unique_key_list_core, bound to the top level.
// Depends on sulc_pkg and sorted_unique_key_list_core_macros.svh.
`timescale 1ns / 1ps
`include "sorted_unique_key_list_core_macros.svh"

module sulc_checker import sulc_pkg::*; #(
  parameter int unsigned DEPTH = 8
) (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_o,
  input logic [1:0]      action_i,
  input logic [KeyW-1:0] key_value_i,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input logic [KeyW-1:0] popped_key_o,
  input logic [2:0]      status_o,
  input logic [3:0]      entries_held_o
);

  // Every input transaction yields a result on the next cycle
  `SULC_ASSERT_NEXT(a_in_gives_out, clk_i, rst_ni, in_valid_i && in_ready_o, out_valid_o)

  // A stalled result holds
  `SULC_ASSERT_NEXT(a_out_holds, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(popped_key_o) && $stable(status_o))

  // Pop on empty leaves an empty list and reports zero
  `SULC_ASSERT_IMP(a_empty_pop, clk_i, rst_ni, out_valid_o && status_o == StEmpty, popped_key_o == '0 && entries_held_o == 4'd0)

  // Count never exceeds capacity, checked only when DEPTH is below 16
  `SULC_ASSERT_IMP(a_count_range, clk_i, rst_ni, out_valid_o && DEPTH < 16, 32'(entries_held_o) <= DEPTH)

  // Full status only when the list is at capacity
  `SULC_ASSERT_IMP(a_full_count, clk_i, rst_ni, out_valid_o && status_o == StFull, 32'(entries_held_o) == (DEPTH % 16))

endmodule

bind sorted_unique_key_list_core sulc_checker #(.DEPTH(DEPTH)) u_sulc_checker (.*);
